### design/ogm_pkg.sv
// ----------------------------------------------------------------------------
// ogm_pkg
// Shared types and constants for the occupancy grid marker.
// ----------------------------------------------------------------------------
package ogm_pkg;

   // grid geometry
   localparam int GRID_WIDTH  = 32;
   localparam int GRID_HEIGHT = 32;
   localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int COL_W       = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
   localparam int ROW_W       = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
   localparam int ADDR_W      = $clog2(GRID_CELLS);

   // pixel -> cell and tile -> cell shifts
   localparam int CELL_SHIFT = 5;
   localparam int TILE_SHIFT = 2;

   // signed working width for box edges in pixels
   localparam int COORD_W = 17;
   localparam logic signed [COORD_W-1:0] COL_LAST = COORD_W'(GRID_WIDTH - 1);
   localparam logic signed [COORD_W-1:0] ROW_LAST = COORD_W'(GRID_HEIGHT - 1);

   localparam logic [7:0] WALL_KIND_A = 8'd1;
   localparam logic [7:0] WALL_KIND_B = 8'd2;

   localparam logic [7:0] WALL_MASK_RESET = 8'd1;

   // register map: one bit of word index
   localparam int         CSR_ADDR_W    = 3;
   localparam logic       REG_WALL_MASK = 1'b0;

   typedef enum logic [1:0] {
      ACT_MARK  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_WALL  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_OR   = 2'd1,
      OP_CLR  = 2'd2,
      OP_ZERO = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic load_init;   // set up the post-reset zeroing sweep
      logic load_item;   // latch a new transaction and its cell range
      logic issue;       // read current cell, advance scan position
      logic emit;        // load the response register
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;       // range holds no cell
      logic last;        // scan position is on the final cell
   } dp_status_type;

endpackage

### design/ogm_ctrl.sv
// ----------------------------------------------------------------------------
// ogm_ctrl
// Sequencer: reset sweep, transaction intake, cell scan, response handoff.
// ----------------------------------------------------------------------------
module ogm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ogm_pkg::ctl_cmd_type   cmd,
   input  ogm_pkg::dp_status_type status
);
   import ogm_pkg::*;

   typedef enum logic [3:0] {
      S_INIT = 4'b0001,
      S_IDLE = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      init_ff, init_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      cmd           = '0;
      case (state_ff)
         S_INIT: begin
            cmd.load_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.empty) begin
               state_in = S_DONE;
            end else begin
               cmd.issue = 1'b1;
               if (status.last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            // trailing write lands on this edge
            if (init_ff) begin
               init_in  = 1'b0;
               state_in = S_IDLE;
            end else if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/ogm_datapath.sv
// ----------------------------------------------------------------------------
// ogm_datapath
// Range setup, scan counters, flag memory read-modify-write, response register.
// ----------------------------------------------------------------------------
module ogm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ogm_pkg::ctl_cmd_type   cmd,
   output ogm_pkg::dp_status_type status,
   input  logic [1:0]             req_action,
   input  logic signed [15:0]     req_pos_x,
   input  logic signed [15:0]     req_pos_y,
   input  logic [7:0]             req_half_width,
   input  logic [7:0]             req_height,
   input  logic [7:0]             req_flag_mask,
   input  logic [6:0]             req_tile_x,
   input  logic [6:0]             req_tile_y,
   input  logic [7:0]             req_tile_kind,
   input  logic [4:0]             req_cell_x,
   input  logic [4:0]             req_cell_y,
   input  logic [7:0]             wall_mask,
   output logic [7:0]             rsp_cell_flags,
   output logic [1:0]             rsp_done_action
);
   import ogm_pkg::*;

   action_type act;
   logic signed [COORD_W-1:0] px, py, hw, ht;
   logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
   logic signed [COORD_W-1:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;
   logic [4:0]                tile_cx, tile_cy;
   logic                      kind_ok, range_empty;
   cell_op_type               op_sel;
   logic [7:0]                mask_sel;

   logic [COL_W-1:0] lo_x_ff, lo_x_in, hi_x_ff, hi_x_in, cur_x_ff, cur_x_in;
   logic [ROW_W-1:0] lo_y_ff, lo_y_in, hi_y_ff, hi_y_in, cur_y_ff, cur_y_in;
   logic             empty_ff, empty_in;
   cell_op_type      op_ff, op_in;
   logic [7:0]       mask_ff, mask_in;
   action_type       action_ff, action_in;

   logic [7:0]        grid_mem [GRID_CELLS];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic              wr_pend_ff, wr_pend_in;
   logic [7:0]        wr_data;

   logic [7:0] rsp_cell_flags_ff, rsp_cell_flags_in;
   logic [1:0] rsp_done_action_ff;

   // ---- range setup from the request ports ----
   assign act     = action_type'(req_action);
   assign px      = {req_pos_x[15], req_pos_x};
   assign py      = {req_pos_y[15], req_pos_y};
   assign hw      = {9'd0, req_half_width};
   assign ht      = {9'd0, req_height};
   assign tile_cx = 5'(req_tile_x >> TILE_SHIFT);
   assign tile_cy = 5'(req_tile_y >> TILE_SHIFT);
   assign kind_ok = (req_tile_kind == WALL_KIND_A) || (req_tile_kind == WALL_KIND_B);

   always_comb begin
      x_lo     = '0;
      x_hi     = COL_LAST;
      y_lo     = '0;
      y_hi     = ROW_LAST;
      op_sel   = OP_ZERO;
      mask_sel = req_flag_mask;
      if (!cmd.load_init) begin
         case (act)
            ACT_MARK: begin
               x_lo   = (px - hw) >>> CELL_SHIFT;
               x_hi   = (px + hw) >>> CELL_SHIFT;
               y_lo   = (py - ht) >>> CELL_SHIFT;
               y_hi   = py >>> CELL_SHIFT;
               op_sel = OP_OR;
            end
            ACT_CLEAR: begin
               op_sel = OP_CLR;
            end
            ACT_WALL: begin
               x_lo     = {12'd0, tile_cx};
               x_hi     = {12'd0, tile_cx};
               y_lo     = {12'd0, tile_cy};
               y_hi     = {12'd0, tile_cy};
               op_sel   = OP_OR;
               mask_sel = wall_mask;
            end
            ACT_READ: begin
               x_lo   = {12'd0, req_cell_x};
               x_hi   = {12'd0, req_cell_x};
               y_lo   = {12'd0, req_cell_y};
               y_hi   = {12'd0, req_cell_y};
               op_sel = OP_NONE;
            end
            default: begin
               op_sel = OP_NONE;
            end
         endcase
      end
   end

   // clamp to grid; a cell beyond the grid lands past the clamped end
   assign x_lo_c = (x_lo < 0) ? '0 : x_lo;
   assign y_lo_c = (y_lo < 0) ? '0 : y_lo;
   assign x_hi_c = (x_hi > COL_LAST) ? COL_LAST : x_hi;
   assign y_hi_c = (y_hi > ROW_LAST) ? ROW_LAST : y_hi;
   assign range_empty = (x_lo_c > x_hi_c) || (y_lo_c > y_hi_c) ||
                        (!cmd.load_init && act == ACT_WALL && !kind_ok);

   // ---- scan counters ----
   assign status.empty = empty_ff;
   assign status.last  = (cur_x_ff == hi_x_ff) && (cur_y_ff == hi_y_ff);

   always_comb begin
      lo_x_in   = lo_x_ff;
      hi_x_in   = hi_x_ff;
      lo_y_in   = lo_y_ff;
      hi_y_in   = hi_y_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      empty_in  = empty_ff;
      op_in     = op_ff;
      mask_in   = mask_ff;
      action_in = action_ff;
      if (cmd.load_init || cmd.load_item) begin
         lo_x_in   = x_lo_c[COL_W-1:0];
         hi_x_in   = x_hi_c[COL_W-1:0];
         lo_y_in   = y_lo_c[ROW_W-1:0];
         hi_y_in   = y_hi_c[ROW_W-1:0];
         cur_x_in  = x_lo_c[COL_W-1:0];
         cur_y_in  = y_lo_c[ROW_W-1:0];
         empty_in  = range_empty;
         op_in     = op_sel;
         mask_in   = mask_sel;
         action_in = cmd.load_init ? ACT_CLEAR : act;
      end else if (cmd.issue) begin
         if (cur_x_ff == hi_x_ff) begin
            cur_x_in = lo_x_ff;
            cur_y_in = cur_y_ff + 1'b1;
         end else begin
            cur_x_in = cur_x_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= 1'b1;
      end else begin
         empty_ff <= empty_in;
      end
      lo_x_ff   <= lo_x_in;
      hi_x_ff   <= hi_x_in;
      lo_y_ff   <= lo_y_in;
      hi_y_ff   <= hi_y_in;
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      op_ff     <= op_in;
      mask_ff   <= mask_in;
      action_ff <= action_in;
   end

   // ---- flag memory: read on issue, write back in the next cycle ----
   assign rd_addr = ADDR_W'(cur_y_ff) * ADDR_W'(GRID_WIDTH) + ADDR_W'(cur_x_ff);
   assign wr_pend_in = cmd.issue && (op_ff != OP_NONE);

   always_comb begin
      case (op_ff)
         OP_OR:   wr_data = rd_data_ff | mask_ff;
         OP_CLR:  wr_data = rd_data_ff & ~mask_ff;
         OP_ZERO: wr_data = '0;
         default: wr_data = rd_data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= grid_mem[rd_addr];
         wr_addr_ff <= rd_addr;
      end
      if (wr_pend_ff) begin
         grid_mem[wr_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= wr_pend_in;
      end
   end

   // ---- response register ----
   assign rsp_cell_flags_in = (action_ff == ACT_READ && !empty_ff) ? rd_data_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_cell_flags_ff  <= rsp_cell_flags_in;
         rsp_done_action_ff <= action_ff;
      end
   end

   assign rsp_cell_flags  = rsp_cell_flags_ff;
   assign rsp_done_action = rsp_done_action_ff;

endmodule

### design/occupancy_grid_marker.sv
// Response: rsp_valid rises after the scan of the cells touched (mark box
//   area, 1 for wall/read, whole grid for clear) and the done state.
// Throughput: the flag memory read-modify-write scan handles one cell per
//   cycle; a new request is taken only once the last one is finished.
// Reset: synchronous; a zeroing sweep over all GRID_CELLS cells runs
//   first, with req_ready low; CSR writes are taken throughout.
// ----------------------------------------------------------------------------
// occupancy_grid_marker
// Coarse broad-phase occupancy grid of 8-bit flag cells (32x32 px each).
// ----------------------------------------------------------------------------
module occupancy_grid_marker (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic signed [15:0]               req_pos_x,
   input  logic signed [15:0]               req_pos_y,
   input  logic [7:0]                       req_half_width,
   input  logic [7:0]                       req_height,
   input  logic [7:0]                       req_flag_mask,
   input  logic [6:0]                       req_tile_x,
   input  logic [6:0]                       req_tile_y,
   input  logic [7:0]                       req_tile_kind,
   input  logic [4:0]                       req_cell_x,
   input  logic [4:0]                       req_cell_y,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_cell_flags,
   output logic [1:0]                       rsp_done_action,
   // APB-style CSR port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ogm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import ogm_pkg::*;

   // Actions:
   //   mark  - OR flag_mask into every cell under the box
   //           [x-hw, x+hw] x [y-h, y], pixel edges shifted down by 5,
   //           clamped to the grid; inverted range touches nothing.
   //   clear - AND ~flag_mask into every cell (full-grid sweep).
   //   wall  - OR wall_mask into the tile's coarse cell (tile >> 2)
   //           for tile kinds 1 and 2 only.
   //   read  - return one cell; zero when the cell is off the grid.
   // Every transaction returns one response echoing the action.

   ctl_cmd_type   cmd;
   dp_status_type status;

   // ---- CSR block: one register, wall_mask at byte address 0 ----
   logic [7:0] wall_mask_ff, wall_mask_in;
   logic       csr_wr;
   logic       reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == REG_WALL_MASK);
   assign csr_wr  = psel && penable && pwrite && reg_hit;

   assign wall_mask_in = csr_wr ? pwdata[7:0] : wall_mask_ff;
   assign prdata       = reg_hit ? {24'd0, wall_mask_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_mask_ff <= WALL_MASK_RESET;
      end else begin
         wall_mask_ff <= wall_mask_in;
      end
   end

   // ---- sequencer ----
   ogm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // ---- range setup, scan, flag memory, response register ----
   ogm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_half_width  (req_half_width),
      .req_height      (req_height),
      .req_flag_mask   (req_flag_mask),
      .req_tile_x      (req_tile_x),
      .req_tile_y      (req_tile_y),
      .req_tile_kind   (req_tile_kind),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .wall_mask       (wall_mask_ff),
      .rsp_cell_flags  (rsp_cell_flags),
      .rsp_done_action (rsp_done_action)
   );

endmodule
